FILE: rtl/sgsg_pkg.sv
// Shared constants, codes and control structs for the stepper step generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sgsg_pkg;

  localparam int NUM_MOTORS = 2;   // motors built, 1 or 2
  localparam int MAX_MOTORS = 2;   // width of the per-motor result bit fields
  localparam int REQ_W      = 3;
  localparam int IDX_W      = 1;
  localparam int POS_W      = 32;
  localparam int CNT_W      = 16;
  localparam int ITER_W     = $clog2(CNT_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MOTOR0 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MOTOR1 = 1'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_SET_GOAL = 3'd1,
    REQ_SET_POS  = 3'd2,
    REQ_SET_EN   = 3'd3,
    REQ_READ     = 3'd4
  } req_e;

  // Command for one motor, already qualified by the addressed motor.
  typedef struct packed {
    logic             apply;
    logic             tick;
    logic             wr_goal;
    logic             wr_pos;
    logic             wr_en;
    logic [POS_W-1:0] value;
  } motor_cmd_t;

  // State of one motor after the command that is applied this cycle.
  typedef struct packed {
    logic             busy;
    logic             step;
    logic             dir;
    logic             en;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] goal;
  } motor_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sgsg_req_if.sv
// Request channel of the stepper step generator: valid, ready and one command word.
// Depends on sgsg_pkg for field widths.
`default_nettype none

interface sgsg_req_if
  import sgsg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] motor_index;
  logic [POS_W-1:0] value;

  modport source (output valid, output req_type, output motor_index, output value,
                  input ready);
  modport sink   (input valid, input req_type, input motor_index, input value,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/sgsg_rsp_if.sv
// Result channel of the stepper step generator: valid, ready and one status word.
// Depends on sgsg_pkg for field widths.
`default_nettype none

interface sgsg_rsp_if
  import sgsg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [MAX_MOTORS-1:0] step_pulses;
  logic [MAX_MOTORS-1:0] directions;
  logic [MAX_MOTORS-1:0] enables;
  logic [POS_W-1:0]      position_out;
  logic [POS_W-1:0]      goal_out;
  logic                  arrived;

  modport source (output valid, output step_pulses, output directions, output enables,
                  output position_out, output goal_out, output arrived, input ready);
  modport sink   (input valid, input step_pulses, input directions, input enables,
                  input position_out, input goal_out, input arrived, output ready);
endinterface

`default_nettype wire

FILE: rtl/sgsg_motor.sv
// One motor: divider counter, position, goal, direction and enable registers,
// plus a bit-serial remainder unit that refits the counter after a period write.
// Depends on sgsg_pkg.
`default_nettype none

module sgsg_motor
  import sgsg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CNT_W-1:0] period_i,
  input  wire logic             period_wr_i,
  input  wire motor_cmd_t       cmd_i,
  output      motor_stat_t      stat_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  goal_q, goal_d;
  logic              dir_q, dir_d;
  logic              en_q, en_d;
  logic              busy_q;
  logic [ITER_W-1:0] iter_q;
  logic [CNT_W-1:0]  num_q;
  logic [CNT_W-1:0]  rem_q, rem_d;

  logic [CNT_W-1:0]  per_eff;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W:0]    rem_shift;
  logic              wrap;
  logic              below;
  logic              above;
  logic              step;

  // A period of zero counts as one.
  assign per_eff = (period_i == '0) ? CNT_W'(1) : period_i;

  // Outside a refit the counter stays below the period, so one compare finds the wrap.
  assign cnt_inc = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign wrap    = (cnt_inc >= {1'b0, per_eff});
  assign below   = ($signed(pos_q) < $signed(goal_q));
  assign above   = ($signed(goal_q) < $signed(pos_q));
  assign step    = cmd_i.apply && cmd_i.tick && wrap && (below || above);

  // One restoring step of count mod period.
  assign rem_shift = {rem_q, num_q[CNT_W-1]};
  assign rem_d     = (rem_shift >= {1'b0, per_eff}) ?
                     CNT_W'(rem_shift - {1'b0, per_eff}) : rem_shift[CNT_W-1:0];

  always_comb begin
    cnt_d  = cnt_q;
    pos_d  = pos_q;
    goal_d = goal_q;
    dir_d  = dir_q;
    en_d   = en_q;
    if (cmd_i.apply) begin
      if (cmd_i.tick) begin
        cnt_d = wrap ? '0 : cnt_inc[CNT_W-1:0];
        if (wrap && below) begin
          pos_d = pos_q + POS_W'(1);
          dir_d = 1'b0;
        end else if (wrap && above) begin
          pos_d = pos_q - POS_W'(1);
          dir_d = 1'b1;
        end
      end
      if (cmd_i.wr_goal) begin
        goal_d = cmd_i.value;
      end
      if (cmd_i.wr_pos) begin
        pos_d = cmd_i.value;
      end
      if (cmd_i.wr_en) begin
        en_d = cmd_i.value[0];
      end
    end else if (busy_q && (iter_q == ITER_W'(CNT_W-1))) begin
      cnt_d = rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pos_q  <= '0;
      goal_q <= '0;
      dir_q  <= 1'b0;
      en_q   <= 1'b1;
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pos_q  <= pos_d;
      goal_q <= goal_d;
      dir_q  <= dir_d;
      en_q   <= en_d;
      if (period_wr_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(CNT_W-1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (period_wr_i) begin
      num_q <= cnt_q;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[CNT_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.step     = step;
  assign stat_o.dir      = dir_d;
  assign stat_o.en       = en_d;
  assign stat_o.position = pos_d;
  assign stat_o.goal     = goal_d;

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q < per_eff))
    else $error("divider count not below the step period");

  a_no_cmd_in_refit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_i.apply)
    else $error("command applied while the counter is refitted");

  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !cmd_i.wr_pos) |=> (pos_q != $past(pos_q)))
    else $error("step pulse without a position change");

endmodule

`default_nettype wire

FILE: rtl/stepper_goal_step_generator_core.sv
// Top level of the two-motor stepper step generator: input register, motor units,
// result selection and result register. Depends on sgsg_pkg, sgsg_req_if,
// sgsg_rsp_if and sgsg_motor.
`default_nettype none

// Each command word (tick, set goal, set position, set enable, read) yields one
// result word. The word is held in the input register and then moves to the
// result register, where its result can be taken. With the result channel ready
// and no divider refit running, one word is accepted per cycle. While a result
// waits to be taken, the input register takes one more word and the request
// channel then stalls until the result moves on. A write to a step period refits
// that motor's divider count with a bit-serial remainder unit; while it runs no
// word is accepted. Step pulses are one result wide: one bit per motor, set on
// the tick word on which it stepped.
module stepper_goal_step_generator_core
  import sgsg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  sgsg_req_if.sink                   req_i,
  sgsg_rsp_if.source                 rsp_o
);

  logic [CNT_W-1:0] period_q [MAX_MOTORS];

  logic             in_vld_q;
  logic [REQ_W-1:0] in_type_q;
  logic [IDX_W-1:0] in_idx_q;
  logic [POS_W-1:0] in_value_q;

  logic                  out_vld_q;
  logic [MAX_MOTORS-1:0] out_step_q, out_dir_q, out_en_q;
  logic [POS_W-1:0]      out_pos_q, out_goal_q;
  logic                  out_arr_q;

  motor_stat_t           stat [MAX_MOTORS];
  logic [MAX_MOTORS-1:0] busy_vec, step_vec, dir_vec, en_vec;
  logic                  busy_any;
  logic                  advance;
  logic                  issue;
  logic                  accept;
  logic                  present;
  logic [POS_W-1:0]      sel_pos, sel_goal;

  assign busy_any = |busy_vec;
  assign advance  = !out_vld_q || rsp_o.ready;
  assign issue    = in_vld_q && advance && !busy_any;
  assign req_i.ready = (!in_vld_q || issue) && !busy_any;
  assign accept   = req_i.valid && req_i.ready;
  assign present  = (int'(in_idx_q) < NUM_MOTORS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < MAX_MOTORS; m++) begin
        period_q[m] <= PERIOD_RESET;
      end
    end else if (cfg_we_i) begin
      period_q[cfg_index_i] <= cfg_data_i;
    end
  end

  for (genvar m = 0; m < MAX_MOTORS; m++) begin : g_motor
    if (m < NUM_MOTORS) begin : g_on
      motor_cmd_t cmd;
      logic       sel;

      assign sel         = (in_idx_q == IDX_W'(m));
      assign cmd.apply   = issue;
      assign cmd.tick    = (in_type_q == REQ_TICK);
      assign cmd.wr_goal = sel && (in_type_q == REQ_SET_GOAL);
      assign cmd.wr_pos  = sel && (in_type_q == REQ_SET_POS);
      assign cmd.wr_en   = sel && (in_type_q == REQ_SET_EN);
      assign cmd.value   = in_value_q;

      sgsg_motor u_motor (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .period_i    (period_q[m]),
        .period_wr_i (cfg_we_i && (cfg_index_i == CFG_IDX_W'(m))),
        .cmd_i       (cmd),
        .stat_o      (stat[m])
      );
    end else begin : g_off
      assign stat[m] = '0;
    end
    assign busy_vec[m] = stat[m].busy;
    assign step_vec[m] = stat[m].step;
    assign dir_vec[m]  = stat[m].dir;
    assign en_vec[m]   = stat[m].en;
  end

  assign sel_pos  = present ? stat[in_idx_q].position : '0;
  assign sel_goal = present ? stat[in_idx_q].goal : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (issue) begin
        in_vld_q <= 1'b0;
      end
      if (issue) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_type_q  <= req_i.req_type;
      in_idx_q   <= req_i.motor_index;
      in_value_q <= req_i.value;
    end
    if (issue) begin
      out_step_q <= step_vec;
      out_dir_q  <= dir_vec;
      out_en_q   <= en_vec;
      out_pos_q  <= sel_pos;
      out_goal_q <= sel_goal;
      out_arr_q  <= present && (sel_pos == sel_goal);
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.step_pulses  = out_step_q;
  assign rsp_o.directions   = out_dir_q;
  assign rsp_o.enables      = out_en_q;
  assign rsp_o.position_out = out_pos_q;
  assign rsp_o.goal_out     = out_goal_q;
  assign rsp_o.arrived      = out_arr_q;

  a_issue_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> out_vld_q)
    else $error("issued word did not reach the result register");

  a_no_accept_in_refit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_any |-> !req_i.ready)
    else $error("word accepted while a divider is refitted");

  a_pulse_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (in_type_q != REQ_TICK)) |=> (out_step_q == '0))
    else $error("step pulse reported for a word that is not a tick");

endmodule

`default_nettype wire
